### design/dgus_pkg.sv
package dgus_pkg;

  localparam int ZONES_PER_SIDE = 8;
  localparam int SAMPLE_BITS    = 12;
  localparam int GRID           = 2 * ZONES_PER_SIDE - 1;
  localparam int ZONE_AW        = $clog2(ZONES_PER_SIDE);
  localparam int COL_W          = $clog2(GRID + 1);
  localparam int ROW_W          = $clog2(GRID + 1);
  localparam int SUM3_W         = SAMPLE_BITS + 2;
  localparam int RECIP3_W       = 16;
  localparam int RECIP3_SH      = 17;
  localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;  // ceil(2^17 / 3)
  localparam logic [7:0] SHADE_MAX = 8'd255;
  localparam logic [7:0] TINT_NUM  = 8'd165;

  typedef logic [SAMPLE_BITS-1:0] dist_t;
  typedef logic [ZONE_AW-1:0]     zaddr_t;

  typedef struct packed {
    logic   we;
    logic   re;
    logic   bank;   // bank that holds the current row
    zaddr_t waddr;
    zaddr_t raddr;
  } store_ctl_t;

  typedef struct packed {
    dist_t prev;
    dist_t cur;
  } zone_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

### design/dgus_row_store.sv
module dgus_row_store
  import dgus_pkg::*;
(
  input  logic       clk,
  input  store_ctl_t ctl,
  input  dist_t      wdata,
  output zone_pair_t rd
);

  dist_t mem0_r [ZONES_PER_SIDE];
  dist_t mem1_r [ZONES_PER_SIDE];
  dist_t rd0_r;
  dist_t rd1_r;

  // ping-pong banks: the current row is written into one, the other holds the previous row
  always_ff @(posedge clk) begin
    if (ctl.we && !ctl.bank) begin
      mem0_r[ctl.waddr] <= wdata;
    end
    if (ctl.we && ctl.bank) begin
      mem1_r[ctl.waddr] <= wdata;
    end
    if (ctl.re) begin
      rd0_r <= mem0_r[ctl.raddr];
      rd1_r <= mem1_r[ctl.raddr];
    end
  end

  assign rd.cur  = ctl.bank ? rd1_r : rd0_r;
  assign rd.prev = ctl.bank ? rd0_r : rd1_r;

endmodule

### design/dgus_shade.sv
module dgus_shade
  import dgus_pkg::*;
(
  input  dist_t distance,
  input  logic  tint,
  output rgb_t  rgb
);

  logic [7:0]  clip;
  logic [7:0]  shade;
  logic [15:0] scaled;
  logic [16:0] div255;

  assign clip   = (distance >= SAMPLE_BITS'(SHADE_MAX)) ? SHADE_MAX : distance[7:0];
  assign shade  = SHADE_MAX - clip;
  assign scaled = 16'(shade) * 16'(TINT_NUM);
  // exact x/255 for x < 255*256
  assign div255 = 17'(scaled) + 17'(scaled[15:8]) + 17'd1;

  always_comb begin
    rgb.red = shade;
    if (tint) begin
      rgb.green = div255[15:8];
      rgb.blue  = 8'd0;
    end else begin
      rgb.green = shade;
      rgb.blue  = shade;
    end
  end

endmodule

### design/depth_grid_upsample_shade_top.sv
// Depth grid upsampler with shading.
// Input channel: one word per zone row (in_zone_0..7, 12-bit mm), rows 0..7 of a
// frame in order; in_valid / in_stall. Output channel: one word per pixel of the
// 15x15 grid (row, mirrored column, distance, RGB shade, last_of_run);
// out_valid / out_stall. cfg_tint_mode is written through cfg_valid / cfg_ready
// (always ready) and picks gray or orange tint; change it only while idle.
// Sequence: an accepted row is first copied into a ping-pong row memory, one zone
// per cycle. Row 0 emits nothing and ends there. Rows 1..6 then emit
// 30 pixels, row 7 emits 45, one per cycle from the memory read loop unless
// out_stall holds it; each pixel passes the read stage, then the output register.
// in_stall is high from acceptance until the last pixel has left the read
// stage; the final pixel may still sit in the output register when the next
// row is taken.
// out_stall holds the output register and the read stage freezes behind it.
// Reset (rst_n low, synchronous) clears the row counter, tint mode and all
// valid flags; the row memory is not cleared.
module depth_grid_upsample_shade_top
  import dgus_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dist_t            in_zone_0,
  input  dist_t            in_zone_1,
  input  dist_t            in_zone_2,
  input  dist_t            in_zone_3,
  input  dist_t            in_zone_4,
  input  dist_t            in_zone_5,
  input  dist_t            in_zone_6,
  input  dist_t            in_zone_7,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] out_pix_row,
  output logic [COL_W-1:0] out_pix_col,
  output dist_t            out_pix_distance,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             out_last_of_run,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_tint_mode
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // phase code doubles as the row offset above 2r-2
  localparam logic [1:0] PH_EVEN_PREV = 2'd0;
  localparam logic [1:0] PH_ODD       = 2'd1;
  localparam logic [1:0] PH_EVEN_CUR  = 2'd2;

  localparam zaddr_t LAST_ROW = ZONE_AW'(ZONES_PER_SIDE - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID - 1);

  logic [1:0]       state_r;
  zaddr_t           row_r;
  zaddr_t           row_nxt;
  logic             bank_r;
  logic             tint_r;
  zaddr_t           ld_cnt_r;
  dist_t            sh_r [ZONES_PER_SIDE];

  logic [COL_W-1:0] iss_c_r;
  logic [1:0]       iss_ph_r;
  logic             iss_more_r;
  logic [COL_W:0]   iss_half;

  logic             s1_v_r;
  logic [COL_W-1:0] s1_c_r;
  logic [1:0]       s1_ph_r;
  dist_t            left_r;
  dist_t            p_held_r;
  dist_t            c_held_r;

  logic             out_v_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  dist_t            out_dist_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_free;
  logic             s1_take;
  logic             issue;
  logic             emit_done;

  store_ctl_t       st_ctl;
  zone_pair_t       st_rd;
  rgb_t             rgb;

  dist_t               e_p;
  dist_t               e_c;
  dist_t               avg_pc;
  logic [SUM3_W-1:0]   sum3;
  logic [SUM3_W+RECIP3_W-1:0] prod3;
  dist_t               q3;
  dist_t               d;
  logic [ROW_W-1:0]    s1_row;
  logic                s1_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_free  = !out_v_r || !out_stall;
  assign s1_take   = s1_v_r && out_free;
  assign issue     = (state_r == ST_EMIT) && iss_more_r && (!s1_v_r || s1_take);
  assign emit_done = (state_r == ST_EMIT) && !iss_more_r && !s1_v_r;
  assign row_nxt   = (row_r == LAST_ROW) ? '0 : row_r + 1'b1;

  // newest zone a column needs: N-1 - (c+1)/2
  assign iss_half  = ((COL_W+1)'(iss_c_r) + 1'b1) >> 1;

  always_comb begin
    st_ctl.we    = (state_r == ST_LOAD);
    st_ctl.re    = issue;
    st_ctl.bank  = bank_r;
    st_ctl.waddr = ld_cnt_r;
    st_ctl.raddr = LAST_ROW - iss_half[ZONE_AW-1:0];
  end

  dgus_row_store u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .wdata (sh_r[0]),
    .rd    (st_rd)
  );

  // pixel value from the read stage; on odd columns held = zone k, new = zone k-1
  assign e_p    = dist_t'(((SAMPLE_BITS+1)'(p_held_r) + (SAMPLE_BITS+1)'(st_rd.prev)) >> 1);
  assign e_c    = dist_t'(((SAMPLE_BITS+1)'(c_held_r) + (SAMPLE_BITS+1)'(st_rd.cur)) >> 1);
  assign avg_pc = dist_t'(((SAMPLE_BITS+1)'(st_rd.prev) + (SAMPLE_BITS+1)'(st_rd.cur)) >> 1);
  assign sum3   = SUM3_W'(e_p) + SUM3_W'(left_r) + SUM3_W'(c_held_r);
  assign prod3  = (SUM3_W+RECIP3_W)'(sum3) * (SUM3_W+RECIP3_W)'(RECIP3);
  assign q3     = prod3[RECIP3_SH +: SAMPLE_BITS];

  always_comb begin
    unique case (s1_ph_r)
      PH_EVEN_PREV: d = s1_c_r[0] ? e_p : st_rd.prev;
      PH_ODD:       d = s1_c_r[0] ? q3  : avg_pc;
      PH_EVEN_CUR:  d = s1_c_r[0] ? e_c : st_rd.cur;
      default:      d = st_rd.prev;
    endcase
  end

  assign s1_row  = ROW_W'({row_r, 1'b0}) + ROW_W'(s1_ph_r) - ROW_W'(2);
  assign s1_last = (s1_c_r == LAST_COL) &&
                   (((s1_ph_r == PH_ODD) && (row_r != LAST_ROW)) ||
                    (s1_ph_r == PH_EVEN_CUR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      row_r      <= '0;
      bank_r     <= 1'b0;
      tint_r     <= 1'b0;
      ld_cnt_r   <= '0;
      iss_c_r    <= '0;
      iss_ph_r   <= PH_EVEN_PREV;
      iss_more_r <= 1'b0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tint_r <= cfg_tint_mode;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r  <= ST_LOAD;
            ld_cnt_r <= '0;
          end
        end
        ST_LOAD: begin
          ld_cnt_r <= ld_cnt_r + 1'b1;
          if (ld_cnt_r == LAST_ROW) begin
            if (row_r == '0) begin
              state_r <= ST_IDLE;
              row_r   <= row_nxt;
              bank_r  <= !bank_r;
            end else begin
              state_r    <= ST_EMIT;
              iss_c_r    <= '0;
              iss_ph_r   <= PH_EVEN_PREV;
              iss_more_r <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_done) begin
            state_r <= ST_IDLE;
            row_r   <= row_nxt;
            bank_r  <= !bank_r;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (issue) begin
        s1_v_r <= 1'b1;
        if (iss_c_r == LAST_COL) begin
          iss_c_r <= '0;
          case (iss_ph_r)
            PH_EVEN_PREV: iss_ph_r <= PH_ODD;
            PH_ODD: begin
              if (row_r == LAST_ROW) begin
                iss_ph_r <= PH_EVEN_CUR;
              end else begin
                iss_more_r <= 1'b0;
              end
            end
            default: iss_more_r <= 1'b0;
          endcase
        end else begin
          iss_c_r <= iss_c_r + 1'b1;
        end
      end else if (s1_take) begin
        s1_v_r <= 1'b0;
      end

      if (s1_take) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sh_r[0] <= in_zone_0;
      sh_r[1] <= in_zone_1;
      sh_r[2] <= in_zone_2;
      sh_r[3] <= in_zone_3;
      sh_r[4] <= in_zone_4;
      sh_r[5] <= in_zone_5;
      sh_r[6] <= in_zone_6;
      sh_r[7] <= in_zone_7;
    end else if (state_r == ST_LOAD) begin
      for (int i = 0; i < ZONES_PER_SIDE - 1; i++) begin
        sh_r[i] <= sh_r[i+1];
      end
    end

    if (issue) begin
      s1_c_r  <= iss_c_r;
      s1_ph_r <= iss_ph_r;
    end

    if (s1_take) begin
      p_held_r   <= st_rd.prev;
      c_held_r   <= st_rd.cur;
      out_row_r  <= s1_row;
      out_col_r  <= s1_c_r;
      out_dist_r <= d;
      out_last_r <= s1_last;
      if (s1_ph_r == PH_ODD) begin
        left_r <= d;
      end
    end
  end

  dgus_shade u_shade (
    .distance (out_dist_r),
    .tint     (tint_r),
    .rgb      (rgb)
  );

  assign out_valid        = out_v_r;
  assign out_pix_row      = out_row_r;
  assign out_pix_col      = out_col_r;
  assign out_pix_distance = out_dist_r;
  assign out_red          = rgb.red;
  assign out_green        = rgb.green;
  assign out_blue         = rgb.blue;
  assign out_last_of_run  = out_last_r;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!s1_v_r && !iss_more_r))
    else $error("read stage busy while idle");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> (out_pix_col == LAST_COL))
    else $error("end of run flagged before the last column");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_ctl.we && st_ctl.re))
    else $error("row store read and written in the same cycle");

  a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_LOAD) && (ld_cnt_r != LAST_ROW)) |=> (state_r == ST_LOAD))
    else $error("row copy cut short");

endmodule
